### src/spq_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted priority queue: queue depth, command and status codes,
// and the types that the cells of the chain exchange. No dependencies.

package spq_pkg;

  localparam int unsigned DEPTH = 16;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Contents of one storage cell.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic signed [15:0] priority_lvl;
  } cell_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [31:0] value;
    logic signed [15:0] priority_lvl;
  } ctrl_t;

endpackage

### src/spq_in_if.sv
`timescale 1ns / 1ps
// Command channel of the sorted priority queue: valid/ready plus the command
// payload. Depends on nothing.

interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] item_value;
  logic signed [15:0] item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

### src/spq_out_if.sv
`timescale 1ns / 1ps
// Result channel of the sorted priority queue: valid/ready plus the dequeued
// word and the status code. Depends on nothing.

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [1:0]         status;

  modport source (output valid, out_value, status, input ready);
  modport sink   (input valid, out_value, status, output ready);
endinterface

### src/spq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one entry and exchanges it with its
// neighbors on a dequeue or an enqueue at or before it. Depends on spq_pkg.

module spq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spq_pkg::ctrl_t ctrl_i,
  input  spq_pkg::cell_t left_i,
  input  logic           left_behind_i,
  input  spq_pkg::cell_t right_i,
  output spq_pkg::cell_t cell_o,
  output logic           behind_o
);

  spq_pkg::cell_t cell_q, cell_d;

  // The new entry belongs at or before this cell: the cell is empty or holds
  // a strictly lower priority, which keeps equal priorities in arrival order.
  assign behind_o = !cell_q.valid || (cell_q.priority_lvl < ctrl_i.priority_lvl);

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.deq) begin
      cell_d = right_i;
    end else if (ctrl_i.enq && behind_o) begin
      if (left_behind_i) begin
        cell_d = left_i;
      end else begin
        cell_d.valid        = 1'b1;
        cell_d.value        = ctrl_i.value;
        cell_d.priority_lvl = ctrl_i.priority_lvl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### src/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of spq_cell instances plus
// the result register. Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
//
//   Channel  Dir  Payload                                  Transaction
//   req_i    in   command, item_value, item_priority       valid & ready
//   rsp_o    out  out_value, status                        valid & ready
//
// Every cell compares its priority with the incoming one in the same cycle, so
// one command can be accepted every cycle while no result is held back.
// The result is written to the output register when the command is accepted.
// A result that is not taken holds the output register, and req_i.ready stays
// low until it leaves. Reset empties the queue at once; no clearing pass.

module sorted_priority_queue_unit (
  input logic      clk_i,
  input logic      rst_ni,
  spq_in_if.sink   req_i,
  spq_out_if.source rsp_o
);

  spq_pkg::cell_t          cells   [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0] behind;
  logic [spq_pkg::DEPTH-1:0] valid_vec;
  logic [spq_pkg::DEPTH-1:0] order_ok;
  spq_pkg::ctrl_t          ctrl;
  spq_pkg::cell_t          tail_in;

  logic               accept;
  logic               empty;
  logic               full;
  logic               rsp_valid_q, rsp_valid_d;
  logic signed [31:0] rsp_value_q, rsp_value_d;
  logic [1:0]         rsp_status_q, rsp_status_d;

  assign empty  = !cells[0].valid;
  assign full   = cells[spq_pkg::DEPTH-1].valid;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept = req_i.valid && req_i.ready;

  assign ctrl.enq = accept && (req_i.command == spq_pkg::CMD_ENQUEUE) && !full;
  assign ctrl.deq = accept && (req_i.command == spq_pkg::CMD_DEQUEUE) && !empty;
  assign ctrl.value        = req_i.item_value;
  assign ctrl.priority_lvl = req_i.item_priority;

  assign tail_in = '0;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .left_i        (tail_in),
        .left_behind_i (1'b0),
        .right_i       (cells[i+1]),
        .cell_o        (cells[i]),
        .behind_o      (behind[i])
      );
    end else if (i == spq_pkg::DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .left_i        (cells[i-1]),
        .left_behind_i (behind[i-1]),
        .right_i       (tail_in),
        .cell_o        (cells[i]),
        .behind_o      (behind[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .left_i        (cells[i-1]),
        .left_behind_i (behind[i-1]),
        .right_i       (cells[i+1]),
        .cell_o        (cells[i]),
        .behind_o      (behind[i])
      );
    end
    assign valid_vec[i] = cells[i].valid;
    if (i == spq_pkg::DEPTH - 1) begin : g_ord_last
      assign order_ok[i] = 1'b1;
    end else begin : g_ord
      assign order_ok[i] = !cells[i+1].valid ||
                           (cells[i].priority_lvl >= cells[i+1].priority_lvl);
    end
  end

  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_value_d  = rsp_value_q;
    rsp_status_d = rsp_status_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
      rsp_value_d = '0;
      case (req_i.command)
        spq_pkg::CMD_DEQUEUE: begin
          if (empty) begin
            rsp_status_d = spq_pkg::ST_EMPTY;
          end else begin
            rsp_status_d = spq_pkg::ST_DEQUEUED;
            rsp_value_d  = cells[0].value;
          end
        end
        default: begin
          rsp_status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_value_q  <= rsp_value_d;
    rsp_status_q <= rsp_status_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.out_value = rsp_value_q;
  assign rsp_o.status    = rsp_status_q;

  // Occupied cells always form a contiguous run starting at the head.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells are not contiguous from the head");

  // Stored priorities never increase along the chain.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("queue is out of priority order");

  // A successful dequeue removes exactly one entry.
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq |=> $countones(valid_vec) == $countones($past(valid_vec)) - 1)
    else $error("dequeue did not remove exactly one entry");

  // A successful enqueue adds exactly one entry.
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
    else $error("enqueue did not add exactly one entry");

endmodule

### tb/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_unit: a directed run, then random
// enqueue/dequeue traffic checked against a behavioral sorted-list model. Depends on
// spq_pkg, spq_in_if, spq_out_if and the RTL of the queue.

module tb_sorted_priority_queue_unit;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } queue_result_t;

  // Sorted-list model of the queue plus the FIFO of results it predicts.
  class spq_scoreboard;
    logic signed [31:0] entry_val[spq_pkg::DEPTH];
    logic signed [15:0] entry_prio[spq_pkg::DEPTH];
    int unsigned        fill;
    queue_result_t      expected_q[$];
    int unsigned        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_command(logic cmd, logic signed [31:0] val,
                               logic signed [15:0] prio);
      queue_result_t res;
      int unsigned   pos;
      int unsigned   i;
      res.value  = '0;
      if (cmd == spq_pkg::CMD_DEQUEUE) begin
        if (fill == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.value = entry_val[0];
          for (i = 1; i < fill; i++) begin
            entry_val[i-1]  = entry_val[i];
            entry_prio[i-1] = entry_prio[i];
          end
          fill--;
          res.status = spq_pkg::ST_DEQUEUED;
        end
      end else begin
        if (fill >= spq_pkg::DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // The new entry goes behind every entry of equal or higher priority.
          pos = fill;
          for (i = 0; i < fill; i++) begin
            if (entry_prio[i] < prio) begin
              pos = i;
              break;
            end
          end
          for (i = fill; i > pos; i--) begin
            entry_val[i]  = entry_val[i-1];
            entry_prio[i] = entry_prio[i-1];
          end
          entry_val[pos]  = val;
          entry_prio[pos] = prio;
          fill++;
          res.status = spq_pkg::ST_ENQUEUED;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] val, logic [1:0] status);
      queue_result_t exp_res;
      if (expected_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result: value %0d status %0d", val, status);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.value !== val || exp_res.status !== status) begin
        if (errors < MAX_REPORTS)
          $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                   exp_res.value, exp_res.status, val, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  spq_scoreboard sb;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  sorted_priority_queue_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
    end
  end

  // Result side: ready stalls at random with the current stall rate.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Both channels are sampled at the rising edge; results come before commands
  // so that a spurious result cannot consume the expectation of this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.out_value, rsp_if.status);
      if (req_if.valid && req_if.ready)
        sb.note_command(req_if.command, req_if.item_value, req_if.item_priority);
    end
  end

  task automatic send_command(input logic cmd, input logic signed [31:0] val,
                              input logic signed [15:0] prio);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         = 1'b1;
    req_if.command       = cmd;
    req_if.item_value    = val;
    req_if.item_priority = prio;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stops sending and waits until every outstanding transaction has a result.
  task automatic drain_queue();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic directed_run();
    int k;
    send_command(spq_pkg::CMD_DEQUEUE, 32'sh12345678, 16'sh7fff);
    send_command(spq_pkg::CMD_ENQUEUE, 32'sd1, 16'sd0);
    send_command(spq_pkg::CMD_ENQUEUE, 32'sd2, 16'sd0);
    send_command(spq_pkg::CMD_ENQUEUE, 32'sd3, 16'sh7fff);
    send_command(spq_pkg::CMD_ENQUEUE, 32'sh7fffffff, 16'sh8000);
    send_command(spq_pkg::CMD_ENQUEUE, 32'sh80000000, 16'sh8000);
    send_command(spq_pkg::CMD_ENQUEUE, 32'sd0, 16'sd0);
    send_command(spq_pkg::CMD_ENQUEUE, -32'sd1, 16'sd1);
    for (k = 0; k < 9; k++)
      send_command(spq_pkg::CMD_ENQUEUE, $urandom, 16'(k) - 16'sd4);
    // The queue holds sixteen entries now, so this insert is dropped.
    send_command(spq_pkg::CMD_ENQUEUE, 32'sh5a5a5a5a, 16'sd100);
    for (k = 0; k < 6; k++)
      send_command(spq_pkg::CMD_DEQUEUE, $urandom, 16'($urandom));
  endtask

  // Bursts lean toward filling or draining so that both full and empty recur.
  task automatic random_run(input int unsigned count);
    int unsigned        k;
    int unsigned        enq_pct;
    logic               cmd;
    logic signed [15:0] prio;
    enq_pct = 50;
    for (k = 0; k < count; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      cmd = ($urandom_range(99) < enq_pct) ? spq_pkg::CMD_ENQUEUE : spq_pkg::CMD_DEQUEUE;
      case ($urandom_range(3))
        0, 1: begin
          prio = 16'($urandom_range(4));
          prio = prio - 16'sd2;
        end
        2: prio = 16'($urandom);
        default: prio = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
      send_command(cmd, $urandom, prio);
    end
  endtask

  initial begin
    sb                   = new();
    cycles               = 0;
    tx_idle_pct          = 0;
    rx_stall_pct         = 0;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.command       = spq_pkg::CMD_ENQUEUE;
    req_if.item_value    = '0;
    req_if.item_priority = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_run();
    random_run(300);
    drain_queue();

    tx_idle_pct = 46;
    random_run(300);
    drain_queue();

    tx_idle_pct  = 0;
    rx_stall_pct = 46;
    random_run(300);
    drain_queue();

    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    random_run(300);
    drain_queue();

    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** sorted_priority_queue_unit: PASSED **");
    end else begin
      $display("** sorted_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/spq_pkg.sv
src/spq_in_if.sv
src/spq_out_if.sv
src/spq_cell.sv
src/sorted_priority_queue_unit.sv
tb/tb_sorted_priority_queue_unit.sv
